// ===== rtl/deque_with_key_removal_macros.svh =====
// assertion macros for the deque_with_key_removal block
// used by files that `include this header; expects clk_i and rst_ni in scope
`ifndef DEQUE_WITH_KEY_REMOVAL_MACROS_SVH
`define DEQUE_WITH_KEY_REMOVAL_MACROS_SVH

// checked on every clock edge outside reset
`define DQK_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked on every clock edge, reset included
`define DQK_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== rtl/dqk_pkg.sv =====
// shared types, codes and constants of the deque_with_key_removal block
// no dependencies
`timescale 1ns / 1ps

package dqk_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int KEY_W       = 16;
  localparam int SCORE_W     = 8;
  localparam int COUNT_OUT_W = 5;

  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [IDX_W-1:0] idx_t;

  localparam cnt_t DEPTH_CNT = cnt_t'(QUEUE_DEPTH);
  localparam cnt_t ONE_CNT   = cnt_t'(1);

  typedef enum logic [1:0] {
    OP_PUSH_TAIL  = 2'd0,
    OP_PUSH_HEAD  = 2'd1,
    OP_POP_HEAD   = 2'd2,
    OP_REMOVE_KEY = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_MISSING = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  // key in the top bits, math score in the bottom bits
  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [SCORE_W-1:0] physics;
    logic [SCORE_W-1:0] history;
    logic [SCORE_W-1:0] math;
  } record_t;

  // controller to datapath
  typedef struct packed {
    logic capture;  // latch item and key match vector
    logic commit;   // apply the operation and latch the result
  } dqk_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic empty;
    logic full;
  } dqk_stat_t;

  // count masked to the result field width
  function automatic logic [COUNT_OUT_W-1:0] count_out(cnt_t c);
    logic [CNT_W+COUNT_OUT_W-1:0] ext;
    ext = (CNT_W + COUNT_OUT_W)'(c);
    return ext[COUNT_OUT_W-1:0];
  endfunction

endpackage

// ===== rtl/dqk_ctrl.sv =====
// sequencing state machine of the deque_with_key_removal block
// depends on dqk_pkg and deque_with_key_removal_macros.svh
`timescale 1ns / 1ps
`include "deque_with_key_removal_macros.svh"

module dqk_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_valid_i,
  output logic             s_ready_o,
  output logic             m_valid_o,
  input  logic             m_ready_i,
  output dqk_pkg::dqk_cmd_t cmd_o,
  input  dqk_pkg::dqk_stat_t stat_i
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e state_q;
  logic   m_valid_q;
  logic   accept;
  logic   commit;

  assign s_ready_o = (state_q == S_IDLE);
  assign accept    = s_valid_i && s_ready_o;
  // result slot must be free (or emptying) before the store changes
  assign commit    = (state_q == S_EXEC) && (!m_valid_q || m_ready_i);

  assign cmd_o.capture = accept;
  assign cmd_o.commit  = commit;
  assign m_valid_o     = m_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      // a new result replaces one that leaves in the same cycle
      if (commit) begin
        m_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (commit) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  `DQK_ASSERT(a_accept_to_exec, accept |=> state_q == S_EXEC, "accepted item did not start")
  `DQK_ASSERT(a_commit_gives_result, commit |=> m_valid_q, "committed item gave no result")
  `DQK_ASSERT(a_empty_full_excl, !(stat_i.empty && stat_i.full), "queue empty and full")
  `DQK_ASSERT_ALWAYS(a_no_result_after_reset, !rst_ni |=> !m_valid_q, "result valid after reset")

endmodule

// ===== rtl/dqk_datapath.sv =====
// record store, key compare and shift logic of the deque_with_key_removal block
// depends on dqk_pkg and deque_with_key_removal_macros.svh
`timescale 1ns / 1ps
`include "deque_with_key_removal_macros.svh"

module dqk_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dqk_pkg::dqk_cmd_t   cmd_i,
  output dqk_pkg::dqk_stat_t  stat_o,
  input  dqk_pkg::op_e        op_i,
  input  dqk_pkg::record_t    rec_i,
  output dqk_pkg::status_e    status_o,
  output dqk_pkg::cnt_t       count_o
);

  dqk_pkg::record_t store_q [dqk_pkg::QUEUE_DEPTH];
  dqk_pkg::record_t store_d [dqk_pkg::QUEUE_DEPTH];
  dqk_pkg::cnt_t    count_q, count_d, count_m1;
  dqk_pkg::op_e     op_q;
  dqk_pkg::record_t rec_q;
  dqk_pkg::status_e status_q, status_d;

  logic [dqk_pkg::QUEUE_DEPTH-1:0] match_d, match_q;
  logic [dqk_pkg::QUEUE_DEPTH-1:0] mid, first_oh, drop_oh, shift_mask;
  dqk_pkg::idx_t last_idx;
  logic full, empty;
  logic do_tail, do_head, do_drop;
  logic seen;

  assign full     = (count_q == dqk_pkg::DEPTH_CNT);
  assign empty    = (count_q == '0);
  assign count_m1 = count_q - dqk_pkg::ONE_CNT;
  assign last_idx = count_m1[dqk_pkg::IDX_W-1:0];

  assign stat_o.empty = empty;
  assign stat_o.full  = full;
  assign status_o     = status_q;
  assign count_o      = count_q;

  // compare the incoming key against every held entry
  always_comb begin
    for (int i = 0; i < dqk_pkg::QUEUE_DEPTH; i++) begin
      match_d[i] = (dqk_pkg::cnt_t'(i) < count_q) && (store_q[i].key == rec_i.key);
    end
  end

  // earliest middle hit, head and tail excluded
  always_comb begin
    mid           = match_q;
    mid[0]        = 1'b0;
    mid[last_idx] = 1'b0;
    seen          = 1'b0;
    for (int i = 0; i < dqk_pkg::QUEUE_DEPTH; i++) begin
      first_oh[i] = mid[i] && !seen;
      seen        = seen || mid[i];
    end
  end

  // operation decode; remove checks head hit, then tail hit, then middle
  always_comb begin
    do_tail  = 1'b0;
    do_head  = 1'b0;
    do_drop  = 1'b0;
    drop_oh  = '0;
    status_d = dqk_pkg::ST_DONE;
    case (op_q)
      dqk_pkg::OP_PUSH_TAIL, dqk_pkg::OP_PUSH_HEAD: begin
        if (full) begin
          status_d = dqk_pkg::ST_FULL;
        end else if (op_q == dqk_pkg::OP_PUSH_TAIL) begin
          do_tail = 1'b1;
        end else begin
          do_head = 1'b1;
        end
      end
      dqk_pkg::OP_POP_HEAD: begin
        if (empty) begin
          status_d = dqk_pkg::ST_EMPTY;
        end else begin
          do_drop    = 1'b1;
          drop_oh[0] = 1'b1;
        end
      end
      dqk_pkg::OP_REMOVE_KEY: begin
        if (empty) begin
          status_d = dqk_pkg::ST_EMPTY;
        end else if (match_q[0]) begin
          do_drop    = 1'b1;
          drop_oh[0] = 1'b1;
        end else if (match_q[last_idx]) begin
          do_drop           = 1'b1;
          drop_oh[last_idx] = 1'b1;
        end else if (|first_oh) begin
          do_drop = 1'b1;
          drop_oh = first_oh;
        end else begin
          status_d = dqk_pkg::ST_MISSING;
        end
      end
      default: begin
        status_d = dqk_pkg::ST_DONE;
      end
    endcase
  end

  // entries at and past the dropped one move one place toward the head
  always_comb begin
    shift_mask[0] = drop_oh[0];
    for (int i = 1; i < dqk_pkg::QUEUE_DEPTH; i++) begin
      shift_mask[i] = shift_mask[i-1] || drop_oh[i];
    end
  end

  always_comb begin
    store_d = store_q;
    count_d = count_q;
    if (do_tail) begin
      store_d[count_q[dqk_pkg::IDX_W-1:0]] = rec_q;
      count_d = count_q + dqk_pkg::ONE_CNT;
    end
    if (do_head) begin
      for (int i = 1; i < dqk_pkg::QUEUE_DEPTH; i++) begin
        store_d[i] = store_q[i-1];
      end
      store_d[0] = rec_q;
      count_d    = count_q + dqk_pkg::ONE_CNT;
    end
    if (do_drop) begin
      for (int i = 0; i < dqk_pkg::QUEUE_DEPTH - 1; i++) begin
        if (shift_mask[i]) begin
          store_d[i] = store_q[i+1];
        end
      end
      count_d = count_m1;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q    <= op_i;
      rec_q   <= rec_i;
      match_q <= match_d;
    end
    if (cmd_i.commit) begin
      store_q  <= store_d;
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.commit) begin
      count_q <= count_d;
    end
  end

  `DQK_ASSERT(a_count_bound, count_q <= dqk_pkg::DEPTH_CNT, "occupancy above depth")
  `DQK_ASSERT(a_single_drop, do_drop |-> $onehot(drop_oh), "drop position not unique")
  `DQK_ASSERT(a_full_keeps, cmd_i.commit && full && !do_drop |=> $stable(count_q), "full push changed occupancy")

endmodule

// ===== rtl/deque_with_key_removal.sv =====
// top level of the deque_with_key_removal block: stream ports, controller, datapath
// depends on dqk_pkg, dqk_ctrl and dqk_datapath
`timescale 1ns / 1ps

// Ordered queue of up to dqk_pkg::QUEUE_DEPTH records (16-bit key, three
// 8-bit scores). Every input transaction carries an opcode in tuser: push at
// tail, push at head, pop head, or remove by key. Remove checks the head
// first, then the tail, then the earliest matching middle entry, and takes
// out only that one. Each input transaction yields exactly one output
// transaction with a status (done, empty, key not found, full) and the
// number of records held afterwards; a failed operation leaves the queue as
// it was. An item is handled in a capture step and a commit step: in the
// capture step the item is latched and its key is compared against all held
// entries at once, in the commit step the store shifts and the result is
// latched into the output register. The next item is taken in the cycle after
// the commit step, so no new item is taken before the last one is through; the
// commit step waits while an earlier result still sits unread in the output
// register. No clearing pass is needed after reset: entries past the occupancy count are never read.

module deque_with_key_removal (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // key [15:0], physics_score [23:16], history_score [31:24], math_score [39:32]
  input  logic [39:0] s_axis_tdata,
  // opcode [1:0]
  input  logic [1:0]  s_axis_tuser,
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status [1:0], entry_count [6:2], zero [7]
  output logic [7:0]  m_axis_tdata
);

  dqk_pkg::dqk_cmd_t  cmd;
  dqk_pkg::dqk_stat_t stat;
  dqk_pkg::record_t   rec;
  dqk_pkg::op_e       op;
  dqk_pkg::status_e   status;
  dqk_pkg::cnt_t      count;

  // unpack the input transaction
  assign op          = dqk_pkg::op_e'(s_axis_tuser);
  assign rec.key     = s_axis_tdata[15:0];
  assign rec.physics = s_axis_tdata[23:16];
  assign rec.history = s_axis_tdata[31:24];
  assign rec.math    = s_axis_tdata[39:32];

  // sequencing: handshakes and command strobes
  dqk_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .cmd_o     (cmd),
    .stat_i    (stat)
  );

  // record store, key compare, shifting and result register
  dqk_datapath u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .stat_o   (stat),
    .op_i     (op),
    .rec_i    (rec),
    .status_o (status),
    .count_o  (count)
  );

  // pack the result transaction; count is masked to the 5-bit field
  assign m_axis_tdata = {1'b0, dqk_pkg::count_out(count), status};

endmodule

// ===== tb/sv/testbench.sv =====
// self-checking testbench for the deque_with_key_removal block
// depends on dqk_pkg and the deque_with_key_removal rtl; a mirror class predicts each result
`timescale 1ns / 1ps

module testbench;
  import dqk_pkg::*;

  // result word as the block should return it
  typedef struct packed {
    status_e                status;
    logic [COUNT_OUT_W-1:0] count;
  } reply_t;

  // mirror of the queue: updated on every accepted request, checked on every reply
  class deque_mirror;
    record_t     held[$];
    reply_t      replies[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
    endfunction

    function int pending();
      return replies.size();
    endfunction

    task report(string what);
      $display("[%0t] mismatch: %s", $time, what);
      mismatches++;
    endtask

    // apply one request to the mirrored queue and queue up the reply it must cause
    task note_request(op_e op, record_t rec);
      status_e st;
      int      last;
      int      hit;
      int      i;
      reply_t  want;
      st  = ST_DONE;
      hit = -1;
      case (op)
        OP_PUSH_TAIL, OP_PUSH_HEAD: begin
          if (held.size() >= QUEUE_DEPTH) st = ST_FULL;
          else if (op == OP_PUSH_TAIL) held.push_back(rec);
          else held.push_front(rec);
        end
        default: begin
          if (held.size() == 0) begin
            st = ST_EMPTY;
          end else if (op == OP_POP_HEAD) begin
            void'(held.pop_front());
          end else begin
            // head first, then tail, then the earliest middle entry
            last = held.size() - 1;
            if (held[0].key == rec.key) hit = 0;
            else if (held[last].key == rec.key) hit = last;
            else
              for (i = 1; i < last; i++)
                if (hit < 0 && held[i].key == rec.key) hit = i;
            if (hit < 0) st = ST_MISSING;
            else held.delete(hit);
          end
        end
      endcase
      want.status = st;
      want.count  = COUNT_OUT_W'(held.size());
      replies.push_back(want);
    endtask

    // compare one reply with the oldest one waiting
    task check_reply(logic [7:0] data);
      reply_t want;
      if (replies.size() == 0) begin
        report($sformatf("result 0x%02h with nothing expected", data));
        return;
      end
      want = replies.pop_front();
      if (data[1:0] !== want.status)
        report($sformatf("status %0d, expected %s", data[1:0], want.status.name()));
      if (data[6:2] !== want.count)
        report($sformatf("entry_count %0d, expected %0d", data[6:2], want.count));
      if (data[7] !== 1'b0)
        report($sformatf("pad bit of result is %b", data[7]));
    endtask
  endclass

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 20;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata  = '0;
  logic [1:0]  s_axis_tuser  = OP_PUSH_TAIL;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;

  deque_mirror mirror = new();

  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  bit          hold_req      = 1'b0;
  int          hold_left     = 0;
  int          cycle_count   = 0;
  bit          filling       = 1'b1;
  logic [15:0] key_pool[8];

  deque_with_key_removal i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // run limit: a hung handshake ends the run here
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[%0t] timeout after %0d cycles", $time, cycle_count);
      $display("Test completed with failures");
      $finish;
    end
  end

  // result side: check each accepted transaction, then pick the next tready
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) mirror.check_reply(m_axis_tdata);
    // a long hold-off lets the output register back up and stall the input
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // offer one request transaction and wait until it is taken; called just after an edge
  task send_item(op_e op, logic [15:0] key, logic [7:0] phys, logic [7:0] hist,
                 logic [7:0] math);
    record_t rec;
    rec.key     = key;
    rec.physics = phys;
    rec.history = hist;
    rec.math    = math;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    // key in the low bits, then physics, history and math
    s_axis_tdata  <= {math, hist, phys, key};
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    mirror.note_request(op, rec);
    // random gaps between requests; valid stays high when there is none
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  // sender stops until every reply has come back
  task wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (mirror.pending() != 0) @(posedge clk_i);
  endtask

  // key choice: removes mostly take a held key, else mostly a small pool, sometimes any 16-bit value
  function logic [15:0] pick_key(bit from_queue);
    if (from_queue && mirror.held.size() != 0 && $urandom_range(0, 99) < 70)
      return mirror.held[$urandom_range(0, mirror.held.size() - 1)].key;
    if ($urandom_range(0, 99) < 80) return key_pool[$urandom_range(0, 7)];
    return 16'($urandom_range(0, 65535));
  endfunction

  // random traffic that swings the queue between empty and full
  task random_phase(int n_items, int s_idle, int r_idle, bit with_hold, bit with_pause);
    int  n;
    int  roll;
    int  size;
    op_e op;
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    for (n = 0; n < n_items; n++) begin
      size = mirror.held.size();
      // turn around near the bounds, with some full pushes and empty pops left in
      if (filling && size >= QUEUE_DEPTH && $urandom_range(0, 99) < 40) filling = 1'b0;
      else if (!filling && size == 0 && $urandom_range(0, 99) < 40) filling = 1'b1;
      else if ($urandom_range(0, 99) < 2) filling = !filling;
      roll = $urandom_range(0, 99);
      if ((filling && roll < 75) || (!filling && roll < 25))
        op = ($urandom_range(0, 1) != 0) ? OP_PUSH_HEAD : OP_PUSH_TAIL;
      else
        op = ($urandom_range(0, 1) != 0) ? OP_REMOVE_KEY : OP_POP_HEAD;
      if (with_hold && n == 60) hold_req = 1'b1;
      if (with_pause && n == n_items / 2) wait_drained();
      send_item(op, pick_key(op == OP_REMOVE_KEY), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    int i;
    key_pool[0] = 16'h0000;
    key_pool[1] = 16'hFFFF;
    for (i = 2; i < 8; i++) key_pool[i] = 16'($urandom_range(0, 65535));

    // reset held low, then released at an edge
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty queue, extremes of the fields, every remove position
    send_item(OP_POP_HEAD,   16'h0000, 8'h00, 8'h00, 8'h00);   // pop on empty
    send_item(OP_REMOVE_KEY, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF);   // remove on empty
    send_item(OP_PUSH_TAIL,  16'h0000, 8'h00, 8'h00, 8'h00);
    send_item(OP_PUSH_HEAD,  16'hFFFF, 8'hFF, 8'hFF, 8'hFF);
    send_item(OP_PUSH_TAIL,  16'h00A5, 8'h5A, 8'hA5, 8'h3C);
    send_item(OP_PUSH_TAIL,  16'h0000, 8'h11, 8'h22, 8'h33);   // duplicate key at tail
    send_item(OP_REMOVE_KEY, 16'h0000, 8'h00, 8'h00, 8'h00);   // tail wins over middle
    send_item(OP_REMOVE_KEY, 16'h00A5, 8'h00, 8'h00, 8'h00);   // tail hit
    send_item(OP_PUSH_TAIL,  16'h00A5, 8'hC3, 8'h3C, 8'h81);
    send_item(OP_PUSH_TAIL,  16'h5A5A, 8'h7E, 8'hE7, 8'h18);
    send_item(OP_REMOVE_KEY, 16'h00A5, 8'h00, 8'h00, 8'h00);   // middle hit
    send_item(OP_REMOVE_KEY, 16'hFFFF, 8'h00, 8'h00, 8'h00);   // head hit
    send_item(OP_REMOVE_KEY, 16'h1234, 8'h00, 8'h00, 8'h00);   // key not found
    send_item(OP_POP_HEAD,   16'h0000, 8'h00, 8'h00, 8'h00);
    // fill up from both ends, then push into the full queue
    for (i = 0; i < QUEUE_DEPTH - 1; i++)
      send_item((i % 2 != 0) ? OP_PUSH_HEAD : OP_PUSH_TAIL, 16'(i * 16'h1111),
                8'(i * 17), 8'(255 - i * 17), 8'(i));
    send_item(OP_PUSH_TAIL,  16'hBEEF, 8'hFF, 8'h00, 8'hFF);   // push on full
    send_item(OP_PUSH_HEAD,  16'hBEEF, 8'h00, 8'hFF, 8'h00);   // push on full

    // random traffic: sender lightly idle, then receiver lightly idle, then free flow
    random_phase(340, 16, 64, 1'b1, 1'b0);
    random_phase(340, 64, 16, 1'b0, 1'b1);
    random_phase(340, 0, 0, 1'b0, 1'b0);

    // drain, then give stray results time to show up
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mirror.pending() != 0)
      mirror.report($sformatf("%0d results never arrived", mirror.pending()));
    if (mirror.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/dqk_pkg.sv
rtl/dqk_ctrl.sv
rtl/dqk_datapath.sv
rtl/deque_with_key_removal.sv
tb/sv/testbench.sv
